// ===== sv/ppm_pkg.sv =====
package ppm_pkg;

  localparam int unsigned ChanW         = 15;
  localparam int unsigned TimeW         = 16;
  localparam int unsigned FrameLenW     = 16;
  localparam int unsigned SlotW         = 3;
  localparam int unsigned MaxChannels   = 6;
  localparam int unsigned SyncTicks     = 300;
  localparam int unsigned MarkTicks     = 400;
  localparam int unsigned FrameLenReset = 20000;

  // APB register map: one 32-bit register every four bytes.
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam logic [2:0] RegFrameLen  = 3'd0;
  localparam logic [2:0] RegChanFirst = 3'd1;
  localparam logic [2:0] RegChanLast  = 3'(RegChanFirst + MaxChannels - 1);

  typedef logic [ChanW-1:0] chan_t;

  localparam chan_t ChanReset [MaxChannels] = '{
    15'd1500, 15'd1200, 15'd1700, 15'd1300, 15'd1800, 15'd1600
  };

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_GAP  = 2'd1,
    PH_MARK = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [SlotW-1:0] slot;
  } position_t;

  typedef struct packed {
    logic tick;
  } tick_item_t;

  typedef struct packed {
    logic line_level;
    logic frame_start;
  } ppm_item_t;

  // Sum of (channel value + mark length) over the first n channels at reset.
  function automatic int unsigned reset_total(input int unsigned n);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < MaxChannels; i++) begin
      if (i < n) begin
        acc = acc + int'(ChanReset[i]) + MarkTicks;
      end
    end
    return acc;
  endfunction

  function automatic position_t next_position(input position_t cur,
                                              input logic [SlotW-1:0] last_slot);
    position_t nxt;
    nxt = cur;
    unique case (cur.phase)
      PH_SYNC: nxt.phase = PH_GAP;
      PH_GAP: begin
        nxt.phase = PH_MARK;
        nxt.slot  = '0;
      end
      PH_MARK: nxt.phase = PH_LOW;
      PH_LOW: begin
        if (cur.slot >= last_slot) begin
          nxt.phase = PH_SYNC;
          nxt.slot  = '0;
        end else begin
          nxt.phase = PH_MARK;
          nxt.slot  = cur.slot + SlotW'(1);
        end
      end
      default: nxt = cur;
    endcase
    return nxt;
  endfunction

endpackage

// ===== sv/ppm_stream_if.sv =====
interface ppm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ppm_frame_generator_top.sv =====
// RC-style PPM frame generator.
// in_if carries one tick per transaction: tick = 1 advances the pulse train by
// one microsecond, tick = 0 only samples the current line level. out_if returns
// exactly one transaction per input transaction, with line_level and a
// frame_start flag that is set on the first tick of each sync mark.
// A frame is a 300-tick sync mark, a low gap of the frame length minus the sum
// of (channel + 400) saturated at zero, then a 400-tick mark and a low time per
// channel. Zero-length low segments are skipped within the same tick.
// The result is registered; one transaction is taken every cycle while the
// skid register is empty. When out_if stalls, one extra result is held in the
// skid register, after which in_if.ready drops until the output drains. The
// APB port (registers at 4*i: frame length, then channels 0 to 5) is to be
// written by the user only while the block is idle; the block does not
// enforce this. Channel writes also update a running channel total so the gap
// is a single subtract. Reset restores the default register values and starts
// a new frame on the first tick.
module ppm_frame_generator_top #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppm_stream_if.sink                    in_if,
  ppm_stream_if.source                  out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ppm_pkg::ApbDataW-1:0]  pwdata,
  output logic [ppm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import ppm_pkg::*;

  localparam int unsigned TotalW =
    $clog2(NUM_CHANNELS * ((2 ** ChanW) - 1 + MarkTicks) + 1);
  localparam int unsigned CmpW = (TotalW > TimeW) ? TotalW : TimeW;
  localparam logic [TotalW-1:0] TotalReset = TotalW'(reset_total(NUM_CHANNELS));
  localparam logic [SlotW-1:0]  LastSlot   = SlotW'(NUM_CHANNELS - 1);

  // Configuration registers.
  logic [FrameLenW-1:0] frame_len_q;
  chan_t                chan_q [MaxChannels];
  logic [TotalW-1:0]    total_q, total_d;

  // Frame position.
  position_t            pos_q, pos_d;
  logic [TimeW-1:0]     time_left_q, time_left_d;

  // Output register and skid stage.
  logic                 out_valid_q, skid_valid_q;
  ppm_item_t            out_data_q, skid_data_q;
  ppm_item_t            result;

  logic                 wr_en, chan_wr;
  logic [2:0]           reg_idx;
  logic [SlotW-1:0]     chan_sel;
  logic                 in_fire, step;
  logic [TimeW-1:0]     gap_len;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign reg_idx  = paddr[ApbAddrW-1:2];
  assign chan_sel = SlotW'(reg_idx - RegChanFirst);
  assign chan_wr  = wr_en && (reg_idx >= RegChanFirst) && (reg_idx <= RegChanLast);

  always_comb begin
    prdata = '0;
    if (reg_idx == RegFrameLen) begin
      prdata = ApbDataW'(frame_len_q);
    end else if ((reg_idx >= RegChanFirst) && (reg_idx <= RegChanLast)) begin
      prdata = ApbDataW'(chan_q[chan_sel]);
    end
  end

  // The running total covers only the active channels, marks included.
  always_comb begin
    total_d = total_q;
    if (chan_wr && (32'(chan_sel) < NUM_CHANNELS)) begin
      total_d = total_q - TotalW'(chan_q[chan_sel]) + TotalW'(pwdata[ChanW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FrameLenW'(FrameLenReset);
      total_q     <= TotalReset;
      for (int unsigned i = 0; i < MaxChannels; i++) begin
        chan_q[i] <= ChanReset[i];
      end
    end else begin
      total_q <= total_d;
      if (wr_en && (reg_idx == RegFrameLen)) begin
        frame_len_q <= pwdata[FrameLenW-1:0];
      end
      if (chan_wr) begin
        chan_q[chan_sel] <= pwdata[ChanW-1:0];
      end
    end
  end

  assign gap_len = (CmpW'(total_q) >= CmpW'(frame_len_q)) ?
                   '0 : TimeW'(CmpW'(frame_len_q) - CmpW'(total_q));

  assign in_if.ready = !skid_valid_q;
  assign in_fire     = in_if.valid & in_if.ready;
  assign step        = in_fire & in_if.data.tick;

  always_comb begin
    position_t        cur;
    logic [TimeW-1:0] len;
    logic [TimeW-1:0] remain;
    logic             start;

    cur    = pos_q;
    remain = time_left_q;
    start  = 1'b0;
    len    = '0;

    if (time_left_q == '0) begin
      unique case (pos_q.phase)
        PH_SYNC: len = TimeW'(SyncTicks);
        PH_GAP:  len = gap_len;
        PH_MARK: len = TimeW'(MarkTicks);
        PH_LOW:  len = TimeW'(chan_q[pos_q.slot]);
        default: len = '0;
      endcase
      // An empty gap or low time is always followed by a mark or a sync mark.
      if (len == '0) begin
        cur = next_position(pos_q, LastSlot);
        len = (cur.phase == PH_SYNC) ? TimeW'(SyncTicks) : TimeW'(MarkTicks);
      end
      start  = (cur.phase == PH_SYNC);
      remain = len;
    end

    pos_d       = pos_q;
    time_left_d = time_left_q;
    if (in_if.data.tick) begin
      result.line_level  = (cur.phase == PH_SYNC) || (cur.phase == PH_MARK);
      result.frame_start = start;
      time_left_d        = remain - TimeW'(1);
      pos_d              = (time_left_d == '0) ? next_position(cur, LastSlot) : cur;
    end else begin
      result.line_level  = (pos_q.phase == PH_SYNC) || (pos_q.phase == PH_MARK);
      result.frame_start = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '{phase: PH_SYNC, slot: '0};
      time_left_q <= '0;
    end else if (step) begin
      pos_q       <= pos_d;
      time_left_q <= time_left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_if.ready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_if.ready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_fire) begin
        out_data_q <= result;
      end
    end else if (in_fire) begin
      skid_data_q <= result;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

endmodule

// ===== tb/ppm_frame_generator_top_test.sv =====
`timescale 1ns / 1ps

module ppm_frame_generator_top_test;
  import ppm_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 10;

  localparam logic [2:0] RegChan0  = RegChanFirst;
  localparam logic [2:0] RegChan1  = 3'(RegChanFirst + 1);
  localparam logic [2:0] RegChan5  = RegChanLast;
  localparam logic [2:0] RegUnused = 3'd7;

  localparam ppm_item_t HiLevel   = '{line_level: 1'b1, frame_start: 1'b0};
  localparam ppm_item_t FrameHead = '{line_level: 1'b1, frame_start: 1'b1};
  localparam ppm_item_t LowLevel  = '{line_level: 1'b0, frame_start: 1'b0};
  localparam ppm_item_t NoCheck   = '{line_level: 1'b0, frame_start: 1'b0};

  typedef enum logic [1:0] {
    ROW_STEP,
    ROW_WRITE,
    ROW_READ
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        tick;
    int unsigned reps;
    logic [2:0]  idx;
    logic [31:0] value;
    bit          typed;
    ppm_item_t   want;
  } row_t;

  localparam int unsigned DirRows = 21;

  // Walks the reset frame through the sync mark into a short gap that follows
  // a channel write, then through a zero channel low time and a short one.
  row_t dir_rows [DirRows] = '{
    '{ROW_STEP,  1'b0,    1, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_READ,  1'b0,    0, RegFrameLen, 32'd20000,     1'b0, NoCheck},
    '{ROW_READ,  1'b0,    0, RegChan0,    32'd1500,      1'b0, NoCheck},
    '{ROW_READ,  1'b0,    0, RegChan5,    32'd1600,      1'b0, NoCheck},
    '{ROW_STEP,  1'b1,    1, RegFrameLen, 32'd0,         1'b1, FrameHead},
    '{ROW_STEP,  1'b0,    1, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_STEP,  1'b1,  299, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_STEP,  1'b0,    1, RegFrameLen, 32'd0,         1'b1, LowLevel},
    '{ROW_WRITE, 1'b0,    0, RegChan0,    32'hFFFF_8000, 1'b0, NoCheck},
    '{ROW_WRITE, 1'b0,    0, RegFrameLen, 32'h0001_2713, 1'b0, NoCheck},
    '{ROW_WRITE, 1'b0,    0, RegUnused,   32'hFFFF_FFFF, 1'b0, NoCheck},
    '{ROW_STEP,  1'b1,    3, RegFrameLen, 32'd0,         1'b1, LowLevel},
    '{ROW_STEP,  1'b1,    1, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_STEP,  1'b1,  399, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_STEP,  1'b0,    1, RegFrameLen, 32'd0,         1'b1, LowLevel},
    '{ROW_STEP,  1'b1,    1, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_STEP,  1'b1,  399, RegFrameLen, 32'd0,         1'b1, HiLevel},
    '{ROW_WRITE, 1'b0,    0, RegChan1,    32'd2,         1'b0, NoCheck},
    '{ROW_READ,  1'b0,    0, RegChan0,    32'd0,         1'b0, NoCheck},
    '{ROW_STEP,  1'b1,    2, RegFrameLen, 32'd0,         1'b1, LowLevel},
    '{ROW_STEP,  1'b1,    1, RegFrameLen, 32'd0,         1'b1, HiLevel}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ppm_stream_if #(.payload_t(tick_item_t)) in_if ();
  ppm_stream_if #(.payload_t(ppm_item_t))  out_if ();

  ppm_frame_generator_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the generator: registers and frame position.
  logic [FrameLenW-1:0] reg_frame;
  chan_t                reg_chan [MaxChannels];
  phase_e               pr_phase;
  logic [SlotW-1:0]     pr_slot;
  logic [TimeW-1:0]     pr_left;

  ppm_item_t   pending_levels [$];
  bit          stalls_on;
  int unsigned failures;
  int unsigned results_checked;
  int unsigned ticks_run;
  int unsigned holds_run;
  int unsigned frames_run;
  int unsigned writes_done;
  int unsigned settings_done;
  int unsigned quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [TimeW-1:0] segment_ticks();
    int unsigned total;
    total = 0;
    case (pr_phase)
      PH_SYNC: return TimeW'(SyncTicks);
      PH_MARK: return TimeW'(MarkTicks);
      PH_LOW:  return TimeW'(reg_chan[pr_slot]);
      default: begin
        for (int i = 0; i < MaxChannels; i++) begin
          total += int'(reg_chan[i]) + MarkTicks;
        end
        return (total >= reg_frame) ? '0 : TimeW'(reg_frame - total);
      end
    endcase
  endfunction

  function automatic void advance_segment();
    case (pr_phase)
      PH_SYNC: pr_phase = PH_GAP;
      PH_GAP: begin
        pr_phase = PH_MARK;
        pr_slot  = '0;
      end
      PH_MARK: pr_phase = PH_LOW;
      default: begin
        if (int'(pr_slot) + 1 >= MaxChannels) begin
          pr_phase = PH_SYNC;
          pr_slot  = '0;
        end else begin
          pr_slot  = pr_slot + 1'b1;
          pr_phase = PH_MARK;
        end
      end
    endcase
  endfunction

  function automatic ppm_item_t predict_line(input logic tick);
    ppm_item_t res;
    logic      head;
    head = 1'b0;
    if (tick) begin
      // Zero-length low segments collapse into the same tick; sync and marks
      // are never empty, so a few passes always suffice.
      for (int n = 0; n < 16 && pr_left == '0; n++) begin
        pr_left = segment_ticks();
        if (pr_left == '0) begin
          advance_segment();
        end else if (pr_phase == PH_SYNC) begin
          head = 1'b1;
        end
      end
    end
    res.line_level  = (pr_phase == PH_SYNC) || (pr_phase == PH_MARK);
    res.frame_start = head;
    if (tick) begin
      pr_left = pr_left - 1'b1;
      if (pr_left == '0) begin
        advance_segment();
      end
    end
    return res;
  endfunction

  // Drops valid and waits until every result of the stream has come back.
  task automatic settle_stream();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_levels.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    settle_stream();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    apb_cycle(1'b1, idx, value, rd);
    writes_done++;
    if (idx == RegFrameLen) begin
      reg_frame = value[FrameLenW-1:0];
      want = 32'(value[FrameLenW-1:0]);
    end else begin
      want = 32'(value[ChanW-1:0]);
      if (idx <= RegChanLast) begin
        reg_chan[idx - RegChanFirst] = value[ChanW-1:0];
      end
    end
    if (idx <= RegChanLast) begin
      apb_cycle(1'b0, idx, '0, rd);
      if (rd !== want) begin
        note_failure($sformatf("register %0d reads %0h, expected %0h", idx, rd, want));
      end
    end
  endtask

  task automatic push_tick(input logic tick, input bit use_typed, input ppm_item_t typed_want);
    ppm_item_t predicted;
    @(negedge clk_i);
    while (stalls_on && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= tick_item_t'(tick);
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    predicted = predict_line(tick);
    if (predicted.frame_start) begin
      frames_run++;
    end
    if (tick) begin
      ticks_run++;
    end else begin
      holds_run++;
    end
    pending_levels.push_back(use_typed ? typed_want : predicted);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= !(stalls_on && $urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin : result_check
    ppm_item_t want;
    ppm_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_levels.size() == 0) begin
        note_failure($sformatf("result %0b/%0b with nothing expected",
                               got.line_level, got.frame_start));
      end else begin
        want = pending_levels.pop_front();
        if (got.line_level !== want.line_level) begin
          note_failure($sformatf("result %0d line_level: expected %0b, got %0b",
                                 results_checked, want.line_level, got.line_level));
        end
        if (got.frame_start !== want.frame_start) begin
          note_failure($sformatf("result %0d frame_start: expected %0b, got %0b",
                                 results_checked, want.frame_start, got.frame_start));
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no transaction for %0d cycles", QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0]      rd;
    logic [15:0]      set_frame;
    logic [ChanW-1:0] set_chan [MaxChannels];
    int unsigned      budget;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    stalls_on    = 1'b1;
    failures     = 0;
    quiet_cycles = 0;
    reg_frame    = FrameLenW'(FrameLenReset);
    reg_chan     = ChanReset;
    pr_phase     = PH_SYNC;
    pr_slot      = '0;
    pr_left      = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirRows; r++) begin
      case (dir_rows[r].kind)
        ROW_STEP: begin
          for (int k = 0; k < dir_rows[r].reps; k++) begin
            push_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].want);
          end
        end
        ROW_WRITE: write_reg(dir_rows[r].idx, dir_rows[r].value);
        default: begin
          apb_cycle(1'b0, dir_rows[r].idx, '0, rd);
          if (rd !== dir_rows[r].value) begin
            note_failure($sformatf("register %0d reads %0h, expected %0h",
                                   dir_rows[r].idx, rd, dir_rows[r].value));
          end
        end
      endcase
    end

    // Each setting reloads every register and then runs a slice of the frame
    // that is under way; the third slice is longer and runs without idling.
    for (int p = 0; p < 8; p++) begin
      stalls_on = (p != 2);
      case (p)
        0: set_frame = 16'($urandom_range(3600, 2400));
        1: set_frame = '0;
        2: set_frame = 16'($urandom_range(3000, 2400));
        3: set_frame = 16'($urandom_range(2800, 0));
        4: set_frame = 16'($urandom_range(3300, 2700));
        5: set_frame = 16'($urandom_range(65535, 0));
        6: set_frame = '1;
        default: set_frame = 16'(FrameLenReset);
      endcase
      for (int c = 0; c < MaxChannels; c++) begin
        case (p)
          0: set_chan[c] = ChanW'($urandom_range(150, 0));
          1: set_chan[c] = '0;
          2: set_chan[c] = ($urandom_range(2) == 0) ? '0 : ChanW'($urandom_range(60, 0));
          3: set_chan[c] = ChanW'($urandom_range(300, 0));
          4: set_chan[c] = ChanW'($urandom_range(80, 0));
          5: set_chan[c] = ChanW'($urandom_range(32767, 0));
          6: set_chan[c] = '1;
          default: set_chan[c] = ChanReset[c];
        endcase
      end
      write_reg(RegFrameLen, ($urandom() & 32'hFFFF_0000) | 32'(set_frame));
      for (int c = 0; c < MaxChannels; c++) begin
        write_reg(3'(RegChanFirst + c), ($urandom() & 32'hFFFF_8000) | 32'(set_chan[c]));
      end
      write_reg(RegUnused, $urandom());
      settings_done++;

      budget = (p == 2) ? 200 : 77;
      for (int k = 0; k < budget; k++) begin
        push_tick($urandom_range(7) != 0, 1'b0, NoCheck);
      end
    end

    settle_stream();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_levels.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_levels.size()));
    end

    $display("Ran %0d ticks and %0d holds, %0d frame starts, %0d results checked.",
             ticks_run, holds_run, frames_run, results_checked);
    $display("Register writes: %0d over %0d random settings plus the directed table.",
             writes_done, settings_done);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ppm_pkg.sv
sv/ppm_stream_if.sv
sv/ppm_frame_generator_top.sv
tb/ppm_frame_generator_top_test.sv
